@@ sv/rgi_pkg.sv @@
// ----------------------------------------------------------------------------
// rgi_pkg
// Shared constants and types for the rgb gradient interpolator.
// ----------------------------------------------------------------------------
package rgi_pkg;

  localparam int COUNT_BITS = 12;
  localparam int CHAN_W     = 8;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = CHAN_W * NUM_CH;
  localparam int NUM_W      = COUNT_BITS + CHAN_W;
  localparam int DIV_W      = COUNT_BITS + CHAN_W + 2;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = CHAN_W / STEP_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LENGTH = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t base;
    logic  neg;
  } lane_ctl_t;

endpackage

@@ sv/rgi_prep.sv @@
// ----------------------------------------------------------------------------
// rgi_prep
// Front stages: clamp the position, take channel differences, multiply and
// form the rounded dividend for each channel.
// ----------------------------------------------------------------------------
module rgi_prep
  import rgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [COUNT_BITS-1:0] in_pos,
  input  logic [COLOR_W-1:0]    start_color,
  input  logic [COLOR_W-1:0]    end_color,
  input  logic [COUNT_BITS-1:0] len,
  output logic                  out_vld,
  output logic [DIV_W-1:0]      out_dvd [NUM_CH],
  output lane_ctl_t             out_ctl [NUM_CH]
);

  logic                  vld1_r, vld2_r, vld3_r;
  logic [COUNT_BITS-1:0] pos1_r;
  chan_t                 mag1_r [NUM_CH];
  lane_ctl_t             ctl1_r [NUM_CH];
  logic [NUM_W-1:0]      num2_r [NUM_CH];
  lane_ctl_t             ctl2_r [NUM_CH];
  logic [DIV_W-1:0]      dvd3_r [NUM_CH];
  lane_ctl_t             ctl3_r [NUM_CH];

  logic [COUNT_BITS-1:0] pos1_nxt;
  chan_t                 mag1_nxt [NUM_CH];
  lane_ctl_t             ctl1_nxt [NUM_CH];
  logic [NUM_W-1:0]      num2_nxt [NUM_CH];
  logic [DIV_W-1:0]      dvd3_nxt [NUM_CH];

  always_comb begin
    chan_t s;
    chan_t e;
    pos1_nxt = (in_pos > len) ? len : in_pos;
    for (int l = 0; l < NUM_CH; l++) begin
      s = start_color[COLOR_W-1-CHAN_W*l -: CHAN_W];
      e = end_color[COLOR_W-1-CHAN_W*l -: CHAN_W];
      ctl1_nxt[l].base = s;
      ctl1_nxt[l].neg  = (e < s);
      mag1_nxt[l]      = (e < s) ? (s - e) : (e - s);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_CH; l++) begin
      num2_nxt[l] = NUM_W'(pos1_r) * NUM_W'(mag1_r[l]);
      dvd3_nxt[l] = DIV_W'({num2_r[l], 1'b0}) + DIV_W'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    pos1_r <= pos1_nxt;
    mag1_r <= mag1_nxt;
    ctl1_r <= ctl1_nxt;
    num2_r <= num2_nxt;
    ctl2_r <= ctl1_r;
    dvd3_r <= dvd3_nxt;
    ctl3_r <= ctl2_r;
  end

  assign out_vld = vld3_r;
  assign out_dvd = dvd3_r;
  assign out_ctl = ctl3_r;

endmodule

@@ sv/rgi_div.sv @@
// ----------------------------------------------------------------------------
// rgi_div
// Pipelined restoring divider for the three channels, two quotient bits
// per stage, divisor twice the span length.
// ----------------------------------------------------------------------------
module rgi_div
  import rgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [DIV_W-1:0]      in_dvd [NUM_CH],
  input  lane_ctl_t             in_ctl [NUM_CH],
  input  logic [COUNT_BITS-1:0] len,
  output logic                  out_vld,
  output chan_t                 out_quo [NUM_CH],
  output lane_ctl_t             out_ctl [NUM_CH]
);

  logic             vld_r [DIV_STAGES];
  chan_t            quo_r [DIV_STAGES][NUM_CH];
  lane_ctl_t        ctl_r [DIV_STAGES][NUM_CH];
  logic [DIV_W-1:0] rem_r [DIV_STAGES][NUM_CH];

  logic             src_vld [DIV_STAGES];
  logic [DIV_W-1:0] src_rem [DIV_STAGES][NUM_CH];
  chan_t            src_quo [DIV_STAGES][NUM_CH];
  lane_ctl_t        src_ctl [DIV_STAGES][NUM_CH];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [DIV_W-1:0] rem_nxt [NUM_CH];
    chan_t            quo_nxt [NUM_CH];

    if (j == 0) begin : g_first
      assign src_vld[j] = in_vld;
      assign src_rem[j] = in_dvd;
      assign src_ctl[j] = in_ctl;
      for (genvar l = 0; l < NUM_CH; l++) begin : g_lane
        assign src_quo[j][l] = '0;
      end
    end else begin : g_next
      assign src_vld[j] = vld_r[j-1];
      assign src_rem[j] = rem_r[j-1];
      assign src_quo[j] = quo_r[j-1];
      assign src_ctl[j] = ctl_r[j-1];
    end

    always_comb begin
      logic [DIV_W-1:0] r;
      logic [DIV_W-1:0] dv;
      chan_t            q;
      for (int l = 0; l < NUM_CH; l++) begin
        r = src_rem[j][l];
        q = src_quo[j][l];
        for (int b = 0; b < STEP_BITS; b++) begin
          dv = DIV_W'({len, 1'b0}) << (CHAN_W - 1 - STEP_BITS * j - b);
          if (r >= dv) begin
            r = r - dv;
            q = q | (chan_t'(1) << (CHAN_W - 1 - STEP_BITS * j - b));
          end
        end
        rem_nxt[l] = r;
        quo_nxt[l] = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= src_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      quo_r[j] <= quo_nxt;
      ctl_r[j] <= src_ctl[j];
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_quo = quo_r[DIV_STAGES-1];
  assign out_ctl = ctl_r[DIV_STAGES-1];

endmodule

@@ sv/rgb_gradient_interpolator.sv @@
// ----------------------------------------------------------------------------
// rgb_gradient_interpolator
// Linear RGB888 gradient: color at a pixel position between a start and an
// end color over a span length, per channel with round half away from zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken at a clock edge with start high and busy low.
//   busy is always low, so a new position can be given every cycle.
//   Output: out_valid marks out_color for exactly one cycle; there is no
//   back pressure, the receiver must take every item when it appears.
//   Pipeline: start to out_valid passes 3 front stages (clamp, multiply and
//   dividend), 4 divider stages at two quotient bits each and 1 output
//   register. Throughput: one item per cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0 start color, 1 end color, 2 span length (zero acts as one);
//   other indexes are ignored. Write only while no item is in flight.
//   Reset: synchronous, active low; clears all valid bits and sets the
//   registers to start 0, end 0, span 1.
// ----------------------------------------------------------------------------
module rgb_gradient_interpolator
  import rgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COUNT_BITS-1:0] in_position,
  output logic                  out_valid,
  output logic [COLOR_W-1:0]    out_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLOR_W-1:0]    start_color_r;
  logic [COLOR_W-1:0]    end_color_r;
  logic [COUNT_BITS-1:0] span_length_r;
  logic [COUNT_BITS-1:0] len;

  logic                  pre_vld;
  logic [DIV_W-1:0]      pre_dvd [NUM_CH];
  lane_ctl_t             pre_ctl [NUM_CH];
  logic                  div_vld;
  chan_t                 div_quo [NUM_CH];
  lane_ctl_t             div_ctl [NUM_CH];

  logic                  out_valid_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic [COLOR_W-1:0]    out_color_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign len       = (span_length_r == '0) ? COUNT_BITS'(1) : span_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= '0;
      end_color_r   <= '0;
      span_length_r <= COUNT_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_COLOR: start_color_r <= cfg_data[COLOR_W-1:0];
        REG_END_COLOR:   end_color_r   <= cfg_data[COLOR_W-1:0];
        REG_SPAN_LENGTH: span_length_r <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  rgi_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (start & ~busy),
    .in_pos      (in_position),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .len         (len),
    .out_vld     (pre_vld),
    .out_dvd     (pre_dvd),
    .out_ctl     (pre_ctl)
  );

  rgi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pre_vld),
    .in_dvd  (pre_dvd),
    .in_ctl  (pre_ctl),
    .len     (len),
    .out_vld (div_vld),
    .out_quo (div_quo),
    .out_ctl (div_ctl)
  );

  always_comb begin
    for (int l = 0; l < NUM_CH; l++) begin
      out_color_nxt[COLOR_W-1-CHAN_W*l -: CHAN_W] =
        div_ctl[l].neg ? (div_ctl[l].base - div_quo[l]) : (div_ctl[l].base + div_quo[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_color = out_color_r;

endmodule

@@ sim/rgb_gradient_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gradient_checker
// Watches the configuration, position and color channels of the gradient
// interpolator, keeps its own copy of the registers, predicts the color of
// every accepted position and compares it with the color that comes out.
// ----------------------------------------------------------------------------
module rgb_gradient_checker
  import rgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [COUNT_BITS-1:0] in_position,
  input  logic                  out_valid,
  input  logic [COLOR_W-1:0]    out_color,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    positions_seen,
  output int                    colors_seen,
  output int                    cfg_writes,
  output int                    errors
);

  logic [COLOR_W-1:0]    start_rgb;
  logic [COLOR_W-1:0]    end_rgb;
  logic [COUNT_BITS-1:0] span_reg;
  logic [COLOR_W-1:0]    expected_colors[$];

  function automatic chan_t blend_channel(chan_t s, chan_t e, int unsigned pos,
                                          int unsigned len);
    int unsigned mag;
    int unsigned q;
    mag = (e < s) ? int'(s) - int'(e) : int'(e) - int'(s);
    q = (2 * pos * mag + len) / (2 * len);
    return (e < s) ? chan_t'(int'(s) - int'(q)) : chan_t'(int'(s) + int'(q));
  endfunction

  function automatic logic [COLOR_W-1:0] color_at(logic [COUNT_BITS-1:0] position);
    int unsigned len;
    int unsigned pos;
    logic [COLOR_W-1:0] rgb;
    len = (span_reg == 0) ? 1 : int'(span_reg);
    pos = (int'(position) > len) ? len : int'(position);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      rgb[ch*CHAN_W +: CHAN_W] = blend_channel(start_rgb[ch*CHAN_W +: CHAN_W],
                                               end_rgb[ch*CHAN_W +: CHAN_W],
                                               pos, len);
    end
    return rgb;
  endfunction

  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (!rst_n) begin
      start_rgb = '0;
      end_rgb   = '0;
      span_reg  = 1;
      expected_colors.delete();
      positions_seen <= 0;
      colors_seen    <= 0;
      cfg_writes     <= 0;
      errors         <= 0;
    end else begin
      if (out_valid) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: color %06h with no item outstanding", $time, out_color);
          errors <= errors + 1;
        end else begin
          want = expected_colors.pop_front();
          colors_seen <= colors_seen + 1;
          if (out_color !== want) begin
            $display("%0t: color mismatch expected %06h actual %06h",
                     $time, want, out_color);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_colors.push_back(color_at(in_position));
        positions_seen <= positions_seen + 1;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes <= cfg_writes + 1;
        case (cfg_index)
          REG_START_COLOR: start_rgb = cfg_data[COLOR_W-1:0];
          REG_END_COLOR:   end_rgb   = cfg_data[COLOR_W-1:0];
          REG_SPAN_LENGTH: span_reg  = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sim/tb_rgb_gradient_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_gradient_interpolator
// Drives positions in random bursts through a series of gradient settings,
// from hand-picked corners to random colors and spans, while a checker beside
// the block predicts and compares every color.
// ----------------------------------------------------------------------------
module tb_rgb_gradient_interpolator;
  import rgi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 17;
  localparam int PHASE_ITEMS  = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [COUNT_BITS-1:0] in_position;
  logic                  out_valid;
  logic [COLOR_W-1:0]    out_color;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int positions_seen;
  int colors_seen;
  int cfg_writes;
  int errors;
  int settings_used;
  int span_now;
  int burst_left;

  rgb_gradient_interpolator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_position(in_position), .out_valid(out_valid), .out_color(out_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rgb_gradient_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_position(in_position), .out_valid(out_valid), .out_color(out_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .positions_seen(positions_seen),
    .colors_seen(colors_seen), .cfg_writes(cfg_writes), .errors(errors)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #5_000_000;
    $display("rgb_gradient_interpolator verification failed");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_SPAN_LENGTH)
      span_now = (data[COUNT_BITS-1:0] == 0) ? 1 : int'(data[COUNT_BITS-1:0]);
  endtask

  task automatic set_gradient(logic [COLOR_W-1:0] from_rgb, logic [COLOR_W-1:0] to_rgb,
                              logic [CFG_DATA_W-1:0] span_data);
    write_reg(REG_START_COLOR, from_rgb);
    write_reg(REG_END_COLOR, to_rgb);
    write_reg(REG_SPAN_LENGTH, span_data);
    settings_used++;
  endtask

  // start stays high on return so the next item can follow back to back
  task automatic send_position(logic [COUNT_BITS-1:0] pos);
    start       <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (positions_seen != colors_seen);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    unique case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_span();
    unique case ($urandom_range(0, 6))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'((1 << COUNT_BITS) - 1);
      3: return CFG_DATA_W'($urandom);
      4, 5: return CFG_DATA_W'($urandom_range(2, 16));
      default: return CFG_DATA_W'($urandom_range(1, (1 << COUNT_BITS) - 1));
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_position();
    int top;
    top = (span_now + 2 > (1 << COUNT_BITS) - 1) ? (1 << COUNT_BITS) - 1 : span_now + 2;
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return COUNT_BITS'(span_now);
      2: return '1;
      3, 4: return COUNT_BITS'($urandom);
      default: return COUNT_BITS'($urandom_range(0, top));
    endcase
  endfunction

  // bursts of random length, some long enough to run without gaps
  task automatic paced_position(logic [COUNT_BITS-1:0] pos);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    send_position(pos);
    burst_left--;
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_position = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_START_COLOR;
    cfg_data    = '0;
    settings_used = 0;
    span_now    = 1;
    burst_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers give black everywhere
    send_position(0);
    send_position(3);
    wait_idle();

    // full ramp up, every channel rising
    set_gradient(24'h000000, 24'hFFFFFF, 4095);
    send_position(0);
    send_position(1);
    send_position(2048);
    send_position(4094);
    send_position(4095);
    wait_idle();

    // falling channels over a one pixel span, position past the end
    set_gradient(24'hFFFFFF, 24'h000000, 1);
    send_position(0);
    send_position(1);
    send_position(4095);
    wait_idle();

    // zero span acts as one
    write_reg(REG_SPAN_LENGTH, 0);
    send_position(0);
    send_position(1);
    wait_idle();

    // exact halves round away from zero both ways
    set_gradient(24'h000000, 24'h010101, 2);
    send_position(1);
    wait_idle();
    set_gradient(24'h010101, 24'h000000, 2);
    send_position(1);
    wait_idle();

    // mixed directions, span data with high bits set
    set_gradient(24'h10F080, 24'hF01080, 24'hFFF003);
    send_position(0);
    send_position(1);
    send_position(2);
    send_position(3);
    send_position(7);
    wait_idle();

    // write to an unused index changes nothing
    write_reg(REG_UNUSED, 24'h000005);
    send_position(2);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_gradient(pick_color(), pick_color(), pick_span());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == PHASES / 2 && i == PHASE_ITEMS / 2)
          wait_idle();
        paced_position(pick_position());
      end
      wait_idle();
    end

    $display("%0d positions interpolated and %0d colors compared", positions_seen,
             colors_seen);
    $display("%0d gradient settings, %0d register writes including unused index",
             settings_used, cfg_writes);
    if (errors == 0 && positions_seen == colors_seen) begin
      $display("rgb_gradient_interpolator verification clean");
    end else begin
      $display("rgb_gradient_interpolator verification failed");
    end
    $finish;
  end

endmodule
